### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_ctrl, spq_datapath and sorted_priority_queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH_DEF        = 10;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;
  localparam int unsigned DATA_W           = 64;
  localparam int unsigned PRIO_W           = 8;
  localparam int unsigned OCC_W            = 4;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_REFUSE
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
  } dp_status_t;

endpackage

### src/spq_ctrl.sv
// Controller FSM: captures a request, then decides the operation on the cell row.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  spq_pkg::dp_status_t status_i,
  output spq_pkg::ctrl_cmd_t  cmd_o
);

  spq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.op    = spq_pkg::OP_NONE;
    busy        = 1'b0;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        busy = 1'b1;
        // refused requests still produce a result, state untouched
        if (status_i.is_remove) begin
          cmd_o.op = status_i.empty ? spq_pkg::OP_REFUSE : spq_pkg::OP_REMOVE;
        end else begin
          cmd_o.op = status_i.full ? spq_pkg::OP_REFUSE : spq_pkg::OP_INSERT;
        end
        state_d = spq_pkg::ST_IDLE;
      end
      default: state_d = spq_pkg::ST_IDLE;
    endcase
  end

endmodule

### src/spq_datapath.sv
// Datapath: request registers, a row of compare-and-shift cells, count and result registers.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int unsigned DEPTH        = spq_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spq_pkg::ctrl_cmd_t          cmd_i,
  output spq_pkg::dp_status_t         status_o,
  input  logic                        req_type_i,
  input  logic [spq_pkg::DATA_W-1:0]  payload_i,
  input  logic [spq_pkg::PRIO_W-1:0]  priority_req_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [spq_pkg::DATA_W-1:0]  data_out_o,
  output logic [spq_pkg::OCC_W-1:0]   occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                        req_type_q;
  logic [PAYLOAD_BITS-1:0]     pay_in_q;
  logic [spq_pkg::PRIO_W-1:0]  pri_in_q;

  logic [PAYLOAD_BITS-1:0]     pay_q [DEPTH];
  logic [PAYLOAD_BITS-1:0]     pay_d [DEPTH];
  logic [spq_pkg::PRIO_W-1:0]  pri_q [DEPTH];
  logic [spq_pkg::PRIO_W-1:0]  pri_d [DEPTH];
  logic [DEPTH-1:0]            gt;
  logic                        we;

  logic [CntW-1:0]             count_q, count_d;
  logic                        done_q, ok_q;
  logic [spq_pkg::DATA_W-1:0]  data_q, data_d;
  logic [spq_pkg::OCC_W-1:0]   occ_q;
  logic [CntW+spq_pkg::OCC_W-1:0] occ_ext;
  logic [spq_pkg::DATA_W+PAYLOAD_BITS-1:0] head_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      pay_in_q   <= payload_i[PAYLOAD_BITS-1:0];
      pri_in_q   <= priority_req_i;
    end
  end

  assign status_o.is_remove = req_type_q;
  assign status_o.full      = (count_q == CntW'(DEPTH));
  assign status_o.empty     = (count_q == '0);

  assign we = (cmd_i.op == spq_pkg::OP_INSERT) || (cmd_i.op == spq_pkg::OP_REMOVE);

  // Row of cells: on insert, stored entries with a larger priority move one slot up
  // and the new entry lands in the first such slot (or at the tail).
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic prev_gt;
    assign gt[k] = (CntW'(k) < count_q) && (pri_q[k] > pri_in_q);
    if (k == 0) begin : g_first
      assign prev_gt = 1'b0;
    end else begin : g_rest
      assign prev_gt = gt[k-1];
    end

    always_comb begin
      pay_d[k] = pay_q[k];
      pri_d[k] = pri_q[k];
      unique case (cmd_i.op)
        spq_pkg::OP_INSERT: begin
          if (prev_gt) begin
            if (k > 0) begin
              pay_d[k] = pay_q[(k > 0) ? k - 1 : 0];
              pri_d[k] = pri_q[(k > 0) ? k - 1 : 0];
            end
          end else if (gt[k] || (CntW'(k) == count_q)) begin
            pay_d[k] = pay_in_q;
            pri_d[k] = pri_in_q;
          end
        end
        spq_pkg::OP_REMOVE: begin
          if (k < DEPTH - 1) begin
            pay_d[k] = pay_q[(k < DEPTH - 1) ? k + 1 : k];
            pri_d[k] = pri_q[(k < DEPTH - 1) ? k + 1 : k];
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        pay_q[k] <= pay_d[k];
        pri_q[k] <= pri_d[k];
      end
    end
  end

  assign head_ext = {{spq_pkg::DATA_W{1'b0}}, pay_q[0]};

  always_comb begin
    count_d = count_q;
    data_d  = '0;
    unique case (cmd_i.op)
      spq_pkg::OP_INSERT: count_d = count_q + CntW'(1);
      spq_pkg::OP_REMOVE: begin
        count_d = count_q - CntW'(1);
        data_d  = head_ext[spq_pkg::DATA_W-1:0];
      end
      default: ;
    endcase
  end

  assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= (cmd_i.op != spq_pkg::OP_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != spq_pkg::OP_NONE) begin
      ok_q   <= we;
      data_q <= data_d;
      occ_q  <= occ_ext[spq_pkg::OCC_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign data_out_o  = data_q;
  assign occupancy_o = occ_q;

endmodule

### src/sorted_priority_queue.sv
// Sorted priority queue: a request is taken at the edge where start is high and busy low.
// The result strobe done_o, registered from the execute state, is high for one cycle.
// Each request is captured, then applied in a compare-and-shift step over the row of entry cells;
// no new request is taken while busy. The receiver cannot stall; each result shows once.
// Reset clears the entry count and the control state; entry contents stay undefined until written.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned DEPTH        = spq_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [spq_pkg::DATA_W-1:0]  payload_i,
  input  logic [spq_pkg::PRIO_W-1:0]  priority_req_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [spq_pkg::DATA_W-1:0]  data_out_o,
  output logic [spq_pkg::OCC_W-1:0]   occupancy_o
);

  spq_pkg::ctrl_cmd_t  cmd;
  spq_pkg::dp_status_t status;

  spq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  spq_datapath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (req_type_i),
    .payload_i      (payload_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .data_out_o     (data_out_o),
    .occupancy_o    (occupancy_o)
  );

  // an accepted transfer always goes to the execute cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not enter execute");

  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("execute lasted more than one cycle");

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy))
    else $error("result strobe without an execute cycle");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> data_out_o == '0)
    else $error("refused request returned nonzero data");

endmodule
